// File: hw/rtl/mxr_pkg.sv
// Shared types and constants for the 3D mesh XYZ route link generator.
// Holds widths, register indexes, controller states and the command and
// status structs passed between controller and datapath. No dependencies.
package mxr_pkg;

	// Fixed field widths
	localparam int NODE_W      = 12;
	localparam int LINK_W      = 14;
	localparam int CFG_W       = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int DEF_MAX_DIM = 16;

	// Divider iteration counter (one quotient bit per cycle over a node index)
	localparam int CNT_W = $clog2(NODE_W);

	// Extent register reset value
	localparam logic [CFG_W-1:0] DIM_RST = 5'd16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP1,
		ST_PREP2,
		ST_CHECK,
		ST_DIV1,
		ST_RELOAD,
		ST_DIV2,
		ST_COORD,
		ST_MUL,
		ST_SUM,
		ST_SEL,
		ST_EMIT_X,
		ST_EMIT_Y,
		ST_EMIT_Z,
		ST_EMIT_ONE
	} state_t;

	typedef enum logic [1:0] {
		LEG_NONE,
		LEG_X,
		LEG_Y,
		LEG_Z
	} leg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic prep1;
		logic prep2;
		logic check;
		logic div_load;
		logic div_second;
		logic div_step;
		logic coord_x;
		logic coord_yz;
		logic mul;
		logic sum;
		leg_t leg;
		logic advance;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic bad_node;
		logic same_node;
		logic nx_zero;
		logic ny_zero;
		logic nz_zero;
		logic rem_one;
	} dp_sts_t;

endpackage

// File: hw/rtl/mxr_div.sv
// Restoring divider lane: one quotient bit per cycle while step is high.
// Used by mxr_dp to split node indices into mesh coordinates. Needs mxr_pkg.
module mxr_div #(
	parameter int NW = mxr_pkg::NODE_W,
	parameter int DW = 5
) (
	input  logic          clk,
	input  logic          load,
	input  logic [NW-1:0] load_val,
	input  logic          step,
	input  logic [DW-1:0] divisor,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	import mxr_pkg::*;

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic          fits;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		fits  = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= load_val;
			rem_q <= '0;
		end else if (step) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? DW'(trial - {1'b0, divisor}) : DW'(trial);
		end
	end

	assign quo = quo_q;
	assign rem = rem_q;

endmodule

// File: hw/rtl/mxr_dp.sv
// Datapath: extent registers, node decomposition, leg start computation
// and the link counter. Depends on mxr_pkg and mxr_div.
module mxr_dp #(
	parameter int MAX_DIM = mxr_pkg::DEF_MAX_DIM
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mxr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mxr_pkg::CFG_W-1:0]     cfg_data,
	input  logic [mxr_pkg::NODE_W-1:0]    source_node,
	input  logic [mxr_pkg::NODE_W-1:0]    dest_node,
	input  mxr_pkg::dp_cmd_t              cmd,
	output mxr_pkg::dp_sts_t              sts,
	output logic [mxr_pkg::LINK_W-1:0]    link_index,
	output logic                          empty_route,
	output logic                          node_error
);
	import mxr_pkg::*;

	localparam int DW  = $clog2(MAX_DIM + 1);
	localparam int CW  = $clog2(MAX_DIM);
	localparam int AW0 = 3 * DW + 2;
	localparam int AW  = (AW0 > LINK_W) ? AW0 : LINK_W;

	// Extent with 0 read as 1 and anything above MAX_DIM read as MAX_DIM
	function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		if (v == '0)
			return DW'(1);
		if (int'(v) > MAX_DIM)
			return DW'(MAX_DIM);
		return DW'(v);
	endfunction

	logic [DW-1:0]     dim_x_q, dim_y_q, dim_z_q;
	logic [NODE_W-1:0] s_q, d_q;
	logic [AW-1:0]     plane_q, a_q, b_q, nodes_q, ybase_q, zbase_q;
	logic [DW-1:0]     div_q;
	logic [CW-1:0]     x0_q, x1_q, y0_q, y1_q, z0_q, z1_q;
	logic [AW-1:0]     mx1_q, mx2_q, my1_q, my2_q, mz1_q, mz2_q;
	logic [CW-1:0]     nx_q, ny_q, nz_q;
	logic [AW-1:0]     xs_q, ys_q, zs_q;
	logic [AW-1:0]     link_q, step_q;
	logic [CW-1:0]     rem_q;
	logic              empty_q, err_q;

	logic [NODE_W-1:0] quo_s, quo_d;
	logic [DW-1:0]     rem_s, rem_d;
	logic [CW-1:0]     xlo, xhi, ylo, yhi, zlo, zhi;

	// Extent registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= clamp_dim(DIM_RST);
			dim_y_q <= clamp_dim(DIM_RST);
			dim_z_q <= clamp_dim(DIM_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIM_X: dim_x_q <= clamp_dim(cfg_data);
				REG_DIM_Y: dim_y_q <= clamp_dim(cfg_data);
				REG_DIM_Z: dim_z_q <= clamp_dim(cfg_data);
				default: ;
			endcase
		end
	end

	// Two divider lanes, source and destination in step
	mxr_div #(.NW(NODE_W), .DW(DW)) u_div_s (
		.clk      (clk),
		.load     (cmd.div_load),
		.load_val (cmd.div_second ? quo_s : s_q),
		.step     (cmd.div_step),
		.divisor  (div_q),
		.quo      (quo_s),
		.rem      (rem_s)
	);

	mxr_div #(.NW(NODE_W), .DW(DW)) u_div_d (
		.clk      (clk),
		.load     (cmd.div_load),
		.load_val (cmd.div_second ? quo_d : d_q),
		.step     (cmd.div_step),
		.divisor  (div_q),
		.quo      (quo_d),
		.rem      (rem_d)
	);

	// Leg bounds
	always_comb begin
		xlo = (x0_q < x1_q) ? x0_q : x1_q;
		xhi = (x0_q < x1_q) ? x1_q : x0_q;
		ylo = (y0_q < y1_q) ? y0_q : y1_q;
		yhi = (y0_q < y1_q) ? y1_q : y0_q;
		zlo = (z0_q < z1_q) ? z0_q : z1_q;
		zhi = (z0_q < z1_q) ? z1_q : z0_q;
	end

	// Per-route arithmetic, one step per command
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			s_q <= source_node;
			d_q <= dest_node;
		end
		// mesh sizes
		if (cmd.prep1) begin
			plane_q <= AW'(dim_x_q) * AW'(dim_y_q);
			a_q     <= AW'(dim_y_q) * AW'(dim_x_q - DW'(1));
			b_q     <= AW'(dim_x_q) * AW'(dim_y_q - DW'(1));
		end
		if (cmd.prep2) begin
			nodes_q <= plane_q * AW'(dim_z_q);
			ybase_q <= a_q * AW'(dim_z_q);
			zbase_q <= (a_q + b_q) * AW'(dim_z_q);
		end
		if (cmd.check) begin
			err_q   <= sts.bad_node;
			empty_q <= !sts.bad_node && sts.same_node;
			link_q  <= '0;
		end
		if (cmd.div_load)
			div_q <= cmd.div_second ? dim_y_q : dim_x_q;
		// coordinates
		if (cmd.coord_x) begin
			x0_q <= CW'(rem_s);
			x1_q <= CW'(rem_d);
		end
		if (cmd.coord_yz) begin
			y0_q <= CW'(rem_s);
			y1_q <= CW'(rem_d);
			z0_q <= CW'(quo_s);
			z1_q <= CW'(quo_d);
		end
		// leg start products and counts
		if (cmd.mul) begin
			mx1_q <= AW'(y0_q) * AW'(dim_x_q - DW'(1));
			mx2_q <= AW'(z0_q) * a_q;
			my1_q <= AW'(ylo) * AW'(dim_x_q);
			my2_q <= AW'(z0_q) * b_q;
			mz1_q <= AW'(y1_q) * AW'(dim_x_q);
			mz2_q <= AW'(zlo) * plane_q;
			nx_q  <= xhi - xlo;
			ny_q  <= yhi - ylo;
			nz_q  <= zhi - zlo;
		end
		if (cmd.sum) begin
			xs_q <= AW'(xlo) + mx1_q + mx2_q;
			ys_q <= ybase_q + AW'(x1_q) + my1_q + my2_q;
			zs_q <= zbase_q + AW'(x1_q) + mz1_q + mz2_q;
		end
		// link counter
		case (cmd.leg)
			LEG_X: begin
				link_q <= xs_q;
				step_q <= AW'(1);
				rem_q  <= nx_q;
			end
			LEG_Y: begin
				link_q <= ys_q;
				step_q <= AW'(dim_x_q);
				rem_q  <= ny_q;
			end
			LEG_Z: begin
				link_q <= zs_q;
				step_q <= plane_q;
				rem_q  <= nz_q;
			end
			default: begin
				if (cmd.advance) begin
					link_q <= link_q + step_q;
					rem_q  <= rem_q - CW'(1);
				end
			end
		endcase
	end

	// Status back to the controller
	always_comb begin
		sts.bad_node  = (AW'(s_q) >= nodes_q) || (AW'(d_q) >= nodes_q);
		sts.same_node = s_q == d_q;
		sts.nx_zero   = nx_q == '0;
		sts.ny_zero   = ny_q == '0;
		sts.nz_zero   = nz_q == '0;
		sts.rem_one   = rem_q == CW'(1);
	end

	assign link_index  = link_q[LINK_W-1:0];
	assign empty_route = empty_q;
	assign node_error  = err_q;

endmodule

// File: hw/rtl/mxr_ctrl.sv
// Controller state machine: sequences set-up, division and link emission.
// Drives datapath commands, reads its status. Depends on mxr_pkg.
module mxr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	output logic             link_valid,
	input  logic             link_stall,
	output logic             last,
	input  mxr_pkg::dp_sts_t sts,
	output mxr_pkg::dp_cmd_t cmd
);
	import mxr_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             cnt_last;
	logic             out_take;

	assign cnt_last = cnt_q == CNT_W'(NODE_W - 1);
	assign out_take = link_valid && !link_stall;

	// State register and divider bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_DIV1 || state_q == ST_DIV2) && !cnt_last)
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_PREP1;
				end
			end
			ST_PREP1: begin
				cmd.prep1 = 1'b1;
				state_d   = ST_PREP2;
			end
			ST_PREP2: begin
				cmd.prep2 = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check    = 1'b1;
				cmd.div_load = 1'b1;
				state_d      = (sts.bad_node || sts.same_node) ? ST_EMIT_ONE : ST_DIV1;
			end
			ST_DIV1: begin
				cmd.div_step = 1'b1;
				if (cnt_last)
					state_d = ST_RELOAD;
			end
			ST_RELOAD: begin
				cmd.coord_x    = 1'b1;
				cmd.div_load   = 1'b1;
				cmd.div_second = 1'b1;
				state_d        = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div_step = 1'b1;
				if (cnt_last)
					state_d = ST_COORD;
			end
			ST_COORD: begin
				cmd.coord_yz = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_SEL;
			end
			// first leg that has links
			ST_SEL: begin
				if (!sts.nx_zero) begin
					cmd.leg = LEG_X;
					state_d = ST_EMIT_X;
				end else if (!sts.ny_zero) begin
					cmd.leg = LEG_Y;
					state_d = ST_EMIT_Y;
				end else begin
					cmd.leg = LEG_Z;
					state_d = ST_EMIT_Z;
				end
			end
			ST_EMIT_X: begin
				if (out_take) begin
					if (!sts.rem_one) begin
						cmd.advance = 1'b1;
					end else if (!sts.ny_zero) begin
						cmd.leg = LEG_Y;
						state_d = ST_EMIT_Y;
					end else if (!sts.nz_zero) begin
						cmd.leg = LEG_Z;
						state_d = ST_EMIT_Z;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT_Y: begin
				if (out_take) begin
					if (!sts.rem_one) begin
						cmd.advance = 1'b1;
					end else if (!sts.nz_zero) begin
						cmd.leg = LEG_Z;
						state_d = ST_EMIT_Z;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT_Z: begin
				if (out_take) begin
					if (!sts.rem_one)
						cmd.advance = 1'b1;
					else
						state_d = ST_IDLE;
				end
			end
			ST_EMIT_ONE: begin
				if (out_take)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake and last-word flag
	always_comb begin
		req_stall  = state_q != ST_IDLE;
		link_valid = state_q inside {ST_EMIT_X, ST_EMIT_Y, ST_EMIT_Z, ST_EMIT_ONE};
		case (state_q)
			ST_EMIT_X:   last = sts.rem_one && sts.ny_zero && sts.nz_zero;
			ST_EMIT_Y:   last = sts.rem_one && sts.nz_zero;
			ST_EMIT_Z:   last = sts.rem_one;
			ST_EMIT_ONE: last = 1'b1;
			default:     last = 1'b0;
		endcase
	end

endmodule

// File: hw/rtl/mesh_xyz_route_link_generator.sv
// Top level of the 3D mesh XYZ route link generator.
// Joins the controller (mxr_ctrl) and the datapath (mxr_dp). Needs mxr_pkg.
//
// Usage:
//   Request channel (req_valid/req_stall) takes one word: source_node and
//   dest_node. Link channel (link_valid/link_stall) returns the route's
//   links one word each in X, then Y, then Z order, last set on the final
//   word. An out-of-mesh node gives a single word with node_error set; equal
//   nodes give a single word with empty_route set.
//   Extents are written through cfg_we/cfg_index/cfg_data while idle.
// Sequence:
//   A route with links is set up by two 12-step passes of the restoring
//   dividers that split both node indices into coordinates (source and
//   destination lanes run side by side). The next request is taken once
//   the block is back in idle after the last word. Error and empty routes
//   skip the divider passes and give their word after the range check.
// Reset: arst_n clears the controller to idle and sets all extents to 16
//   (capped at MAX_DIM). While the receiver stalls, the current word holds
//   and the request side stays stalled.
module mesh_xyz_route_link_generator #(
	parameter int MAX_DIM = mxr_pkg::DEF_MAX_DIM
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mxr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mxr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [mxr_pkg::NODE_W-1:0]    source_node,
	input  logic [mxr_pkg::NODE_W-1:0]    dest_node,
	output logic                          link_valid,
	input  logic                          link_stall,
	output logic [mxr_pkg::LINK_W-1:0]    link_index,
	output logic                          last,
	output logic                          empty_route,
	output logic                          node_error
);
	import mxr_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer
	mxr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.link_valid (link_valid),
		.link_stall (link_stall),
		.last       (last),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Arithmetic and link counter
	mxr_dp #(.MAX_DIM(MAX_DIM)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.source_node (source_node),
		.dest_node   (dest_node),
		.cmd         (cmd),
		.sts         (sts),
		.link_index  (link_index),
		.empty_route (empty_route),
		.node_error  (node_error)
	);

endmodule

// File: tb/mesh_xyz_route_link_generator_tb.sv
`timescale 1ns / 1ps
// Testbench for mesh_xyz_route_link_generator: drives routes, predicts link words, checks them.
// Depends on mxr_pkg and the generator RTL. Randomised idling on both channels.
module mesh_xyz_route_link_generator_tb;
	import mxr_pkg::*;

	typedef struct packed {
		logic [LINK_W-1:0] link;
		logic              last;
		logic              empty;
		logic              err;
	} link_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 req_valid;
	logic                 req_stall;
	logic [NODE_W-1:0]    source_node;
	logic [NODE_W-1:0]    dest_node;
	logic                 link_valid;
	logic                 link_stall;
	logic [LINK_W-1:0]    link_index;
	logic                 last;
	logic                 empty_route;
	logic                 node_error;

	// Effective mesh extents as the block sees them
	int unsigned mesh_x, mesh_y, mesh_z;
	link_word_t  pending_links[$];
	int          fail_count;
	bit          idling_on;

	mesh_xyz_route_link_generator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.source_node (source_node),
		.dest_node   (dest_node),
		.link_valid  (link_valid),
		.link_stall  (link_stall),
		.link_index  (link_index),
		.last        (last),
		.empty_route (empty_route),
		.node_error  (node_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Receiver stalls in random bursts
	initial begin
		link_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 5) == 0) begin
				link_stall = 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				link_stall = 1'b0;
			end
		end
	end

	// Compare each accepted link word with the oldest expected one
	always @(posedge clk) begin
		link_word_t want;
		if (arst_n && link_valid && !link_stall) begin
			if (pending_links.size() == 0) begin
				$display("%0t: expected none, got %0d/%0b/%0b/%0b",
					$time, link_index, last, empty_route, node_error);
				fail_count++;
			end else begin
				want = pending_links.pop_front();
				if (link_index !== want.link || last !== want.last ||
						empty_route !== want.empty || node_error !== want.err) begin
					$display("%0t: expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
						$time, want.link, want.last, want.empty, want.err,
						link_index, last, empty_route, node_error);
					fail_count++;
				end
			end
		end
	end

	function automatic int unsigned clamp_extent(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > DEF_MAX_DIM)
			return DEF_MAX_DIM;
		return 32'(v);
	endfunction

	function automatic link_word_t make_word(input int unsigned link, input bit fin,
			input bit emp, input bit bad);
		link_word_t w;
		w.link  = link[LINK_W-1:0];
		w.last  = fin;
		w.empty = emp;
		w.err   = bad;
		return w;
	endfunction

	// Expected link words for one route: X leg, then Y, then Z, ascending
	task automatic predict_route(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
		int unsigned plane, nodes, sx, sy, sz, dx, dy, dz, lo, hi, ybase, zbase;
		int unsigned links[$];
		plane = mesh_x * mesh_y;
		nodes = plane * mesh_z;
		if (src >= nodes || dst >= nodes) begin
			pending_links = {pending_links, make_word(0, 1'b1, 1'b0, 1'b1)};
			return;
		end
		if (src == dst) begin
			pending_links = {pending_links, make_word(0, 1'b1, 1'b1, 1'b0)};
			return;
		end
		sx = src % mesh_x; sy = (src / mesh_x) % mesh_y; sz = src / plane;
		dx = dst % mesh_x; dy = (dst / mesh_x) % mesh_y; dz = dst / plane;
		ybase = mesh_z * mesh_y * (mesh_x - 1);
		zbase = mesh_z * (2 * plane - mesh_x - mesh_y);
		lo = (sx < dx) ? sx : dx;
		hi = (sx < dx) ? dx : sx;
		for (int unsigned c = lo; c < hi; c++)
			links = {links, c + sy * (mesh_x - 1) + sz * mesh_y * (mesh_x - 1)};
		lo = (sy < dy) ? sy : dy;
		hi = (sy < dy) ? dy : sy;
		for (int unsigned c = lo; c < hi; c++)
			links = {links, ybase + dx + c * mesh_x + sz * mesh_x * (mesh_y - 1)};
		lo = (sz < dz) ? sz : dz;
		hi = (sz < dz) ? dz : sz;
		for (int unsigned c = lo; c < hi; c++)
			links = {links, zbase + dx + dy * mesh_x + c * plane};
		foreach (links[i])
			pending_links = {pending_links,
				make_word(links[i], i == links.size() - 1, 1'b0, 1'b0)};
	endtask

	// Offer one route request; returns at the falling edge after acceptance
	task automatic send_route(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		req_valid   = 1'b1;
		source_node = src;
		dest_node   = dst;
		do
			@(posedge clk);
		while (req_stall);
		predict_route(src, dst);
		@(negedge clk);
	endtask

	// Let every expected word arrive, then allow the block to settle
	task automatic wait_idle();
		req_valid = 1'b0;
		while (pending_links.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_extent(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_DIM_X: mesh_x = clamp_extent(val);
			REG_DIM_Y: mesh_y = clamp_extent(val);
			REG_DIM_Z: mesh_z = clamp_extent(val);
			default: ;
		endcase
	endtask

	task automatic set_mesh(input logic [CFG_W-1:0] vx, input logic [CFG_W-1:0] vy,
			input logic [CFG_W-1:0] vz);
		wait_idle();
		write_extent(REG_DIM_X, vx);
		write_extent(REG_DIM_Y, vy);
		write_extent(REG_DIM_Z, vz);
	endtask

	// Reset extents: longest route, corners, single-leg routes, equal nodes
	task automatic test_full_mesh();
		send_route(12'd0, 12'd4095);
		send_route(12'd4095, 12'd0);
		send_route(12'd0, 12'd0);
		send_route(12'd4095, 12'd4095);
		send_route(12'd1, 12'd0);
		send_route(12'd0, 12'd16);
		send_route(12'd0, 12'd256);
		send_route(12'hAAA, 12'h555);
		send_route(12'h555, 12'hAAA);
	endtask

	// Small mesh: nodes beyond it, error taking priority over equal nodes
	task automatic test_node_errors();
		set_mesh(5'd3, 5'd2, 5'd4);
		send_route(12'd24, 12'd0);
		send_route(12'd0, 12'd24);
		send_route(12'd4095, 12'd4095);
		send_route(12'd100, 12'd100);
		send_route(12'd23, 12'd0);
		send_route(12'd0, 12'd23);
	endtask

	// Extent writes of zero and beyond the maximum
	task automatic test_extent_limits();
		set_mesh(5'd0, 5'd0, 5'd0);
		send_route(12'd0, 12'd0);
		send_route(12'd0, 12'd1);
		set_mesh(5'd31, 5'd17, 5'd1);
		send_route(12'd0, 12'd255);
		send_route(12'd255, 12'd256);
		set_mesh(5'd1, 5'd16, 5'd31);
		send_route(12'd0, 12'd255);
		send_route(12'd17, 12'd200);
	endtask

	// Random routes over several meshes; the last phase runs without idling
	task automatic test_random_routes();
		int unsigned nodes;
		logic [NODE_W-1:0] src, dst;
		int kind;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_mesh(5'd16, 5'd16, 5'd16);
				1: set_mesh(5'd2, 5'd2, 5'd2);
				default: set_mesh(CFG_W'($urandom_range(0, 31)),
					CFG_W'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 31)));
			endcase
			if (ph == 5)
				idling_on = 1'b0;
			nodes = mesh_x * mesh_y * mesh_z;
			for (int i = 0; i < 50; i++) begin
				kind = $urandom_range(0, 99);
				src  = NODE_W'($urandom_range(0, nodes - 1));
				dst  = NODE_W'($urandom_range(0, nodes - 1));
				if (kind < 8) begin
					dst = src;
				end else if (kind < 16 && nodes < 4096) begin
					if (kind < 12)
						src = NODE_W'($urandom_range(nodes, 4095));
					else
						dst = NODE_W'($urandom_range(nodes, 4095));
				end else if (kind < 20) begin
					src = NODE_W'($urandom);
					dst = NODE_W'($urandom);
				end
				send_route(src, dst);
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_DIM_X;
		cfg_data    = '0;
		req_valid   = 1'b0;
		source_node = '0;
		dest_node   = '0;
		fail_count  = 0;
		idling_on   = 1'b1;
		mesh_x      = 16;
		mesh_y      = 16;
		mesh_z      = 16;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_full_mesh();
		test_node_errors();
		test_extent_limits();
		test_random_routes();

		// Drain, then watch for stray words
		wait_idle();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
